### rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg: shared types and constants of the request header parser
// Request item, queue status, mode and event codes, and the path prefix.
// ----------------------------------------------------------------------------
package hrp_pkg;

   // request modes
   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_OPEN = 2'd2;

   // result events
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_PATH_BYTE = 3'd1;
   localparam logic [2:0] EV_PATH_DONE = 3'd2;
   localparam logic [2:0] EV_HDR_DONE  = 3'd3;
   localparam logic [2:0] EV_WS_DONE   = 3'd4;
   localparam logic [2:0] EV_CLOSE     = 3'd5;

   // characters
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_CONN  = 1'b1;
   localparam logic [15:0] IDLE_LIMIT_RESET = 16'd100;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;

   localparam int unsigned PREFIX_LEN = 5;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data;
      logic       is_space;
      logic       is_lf;
      logic       is_cr;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   // "/d/ws"
   function automatic logic [7:0] ws_prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h2f;
         3'd1: ch = 8'h64;
         3'd2: ch = 8'h2f;
         3'd3: ch = 8'h77;
         3'd4: ch = 8'h73;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/http_request_header_parser_top.sv
// path: a request accepted into the front stage register passes through a queue entry to the
// result register, and is held back while the result side stalls
// throughput: one request per cycle while req_stall is low, set by the state update
// in the back end; a four-entry queue absorbs short result stalls
// reset: synchronous, active high; parser returns to no connection, idle
// limit to 100 ticks, keep-connection off, queue and result register empty
// ----------------------------------------------------------------------------
// http_request_header_parser_top: request line and header parser
// Front intake, request queue and back-end parser state machine.
// ----------------------------------------------------------------------------
module http_request_header_parser_top #(
   parameter int unsigned PATH_BYTES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [7:0]                      req_byte_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_event_res,
   output logic [7:0]                      rsp_path_byte,
   output logic [5:0]                      rsp_path_length,
   output logic                            rsp_is_websocket,
   input  logic                            csr_write_enable,
   input  logic [hrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hrp_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import hrp_pkg::*;

   q_status_type q_status;
   item_type     push_item;
   item_type     pop_item;
   logic         push;
   logic         pop;

   hrp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_byte_value (req_byte_value),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   hrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   hrp_back #(
      .PATH_BYTES (PATH_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .pop_item         (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_path_byte    (rsp_path_byte),
      .rsp_path_length  (rsp_path_length),
      .rsp_is_websocket (rsp_is_websocket)
   );

endmodule

### rtl/hrp_front.sv
// ----------------------------------------------------------------------------
// hrp_front: request intake and byte classification
// Registers each request with its character class and hands it to the queue.
// ----------------------------------------------------------------------------
module hrp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic [7:0]           req_byte_value,
   input  hrp_pkg::q_status_type q_status,
   output logic                 push,
   output hrp_pkg::item_type    push_item
);
   import hrp_pkg::*;

   logic     stage_valid_ff, stage_valid_in;
   item_type stage_item_ff, stage_item_in;
   logic     take;

   assign push      = stage_valid_ff && !q_status.full;
   assign req_stall = stage_valid_ff && q_status.full;
   assign take      = req_valid && !req_stall;
   assign push_item = stage_item_ff;

   always_comb begin
      stage_item_in.mode     = req_mode;
      stage_item_in.data     = req_byte_value;
      stage_item_in.is_space = (req_byte_value == CHAR_SPACE);
      stage_item_in.is_lf    = (req_byte_value == CHAR_LF);
      stage_item_in.is_cr    = (req_byte_value == CHAR_CR);
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_item_ff <= stage_item_in;
      end
   end

endmodule

### rtl/hrp_queue.sv
// ----------------------------------------------------------------------------
// hrp_queue: short request queue between front and back
// Circular buffer with separate read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module hrp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hrp_pkg::item_type     push_item,
   input  logic                  pop,
   output hrp_pkg::item_type     pop_item,
   output hrp_pkg::q_status_type q_status
);
   import hrp_pkg::*;

   item_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign pop_item           = entries_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with empty count");
`endif

endmodule

### rtl/hrp_back.sv
// ----------------------------------------------------------------------------
// hrp_back: parser state machine and result register
// Applies each queued request to the connection state and registers the result.
// ----------------------------------------------------------------------------
module hrp_back #(
   parameter int unsigned PATH_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [hrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hrp_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  hrp_pkg::q_status_type          q_status,
   input  hrp_pkg::item_type              pop_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_event_res,
   output logic [7:0]                    rsp_path_byte,
   output logic [5:0]                    rsp_path_length,
   output logic                          rsp_is_websocket
);
   import hrp_pkg::*;

   localparam int unsigned CNT_W = $clog2(PATH_BYTES);
   localparam logic [CNT_W-1:0] KEEP_MAX   = CNT_W'(PATH_BYTES - 2);
   localparam logic [CNT_W-1:0] PREFIX_CNT = CNT_W'(PREFIX_LEN);

   localparam logic [3:0] PH_NONE    = 4'd0;
   localparam logic [3:0] PH_METHOD  = 4'd1;
   localparam logic [3:0] PH_PATH    = 4'd2;
   localparam logic [3:0] PH_PROTO   = 4'd3;
   localparam logic [3:0] PH_FLAG    = 4'd4;
   localparam logic [3:0] PH_INFLAG  = 4'd5;
   localparam logic [3:0] PH_XFER    = 4'd6;
   localparam logic [3:0] PH_WS      = 4'd7;
   localparam logic [3:0] PH_WS_OPEN = 4'd8;
   localparam logic [3:0] PH_CLOSE   = 4'd9;

   localparam logic [1:0] WS_KEY  = 2'd0;
   localparam logic [1:0] WS_LINE = 2'd1;
   localparam logic [1:0] WS_LF   = 2'd2;
   localparam logic [1:0] WS_LFCR = 2'd3;

   logic [15:0]      idle_limit_ff;
   logic             keep_conn_ff;
   logic [3:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             prefix_ff, prefix_in;
   logic [1:0]       ws_sub_ff, ws_sub_in;
   logic [15:0]      idle_ff, idle_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       event_ff, event_in;
   logic [7:0]       pbyte_ff, pbyte_in;
   logic [5:0]       plen_ff, plen_in;
   logic             ws_ff, ws_in;
   logic             take;
   logic             is_ws;

   assign take = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = take;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_path_byte    = pbyte_ff;
   assign rsp_path_length  = plen_ff;
   assign rsp_is_websocket = ws_ff;

   assign is_ws = prefix_ff && (count_ff >= PREFIX_CNT);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      prefix_in = prefix_ff;
      ws_sub_in = ws_sub_ff;
      idle_in  = idle_ff;
      event_in = EV_NONE;
      pbyte_in = 8'd0;
      plen_in  = 6'd0;
      ws_in    = 1'b0;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
      if (take) begin
         case (pop_item.mode)
            MODE_BYTE: begin
               idle_in = 16'd0;
               case (phase_ff)
                  PH_METHOD: begin
                     if (pop_item.is_space) begin
                        phase_in  = PH_PATH;
                        count_in  = '0;
                        prefix_in = 1'b1;
                     end
                  end
                  PH_PATH: begin
                     if (pop_item.is_space) begin
                        plen_in  = 6'(count_ff);
                        ws_in    = is_ws;
                        event_in = EV_PATH_DONE;
                        count_in = '0;
                        if (is_ws) begin
                           phase_in  = PH_WS;
                           ws_sub_in = WS_KEY;
                        end else begin
                           phase_in = PH_PROTO;
                        end
                     end else if (count_ff < KEEP_MAX) begin
                        if (count_ff < PREFIX_CNT
                            && pop_item.data != ws_prefix_char(count_ff[2:0])) begin
                           prefix_in = 1'b0;
                        end
                        count_in = count_ff + 1'b1;
                        pbyte_in = pop_item.data;
                        event_in = EV_PATH_BYTE;
                     end
                  end
                  PH_PROTO: begin
                     if (pop_item.is_lf) begin
                        phase_in = PH_FLAG;
                     end
                  end
                  PH_FLAG: begin
                     if (pop_item.is_lf) begin
                        phase_in = PH_XFER;
                        event_in = EV_HDR_DONE;
                     end else if (!pop_item.is_cr) begin
                        phase_in = PH_INFLAG;
                     end
                  end
                  PH_INFLAG: begin
                     if (pop_item.is_lf) begin
                        phase_in = PH_FLAG;
                     end
                  end
                  PH_WS: begin
                     // newline, CR, newline ends a websocket request
                     case (ws_sub_ff)
                        WS_KEY: ws_sub_in = WS_LINE;
                        WS_LINE: begin
                           if (pop_item.is_lf) begin
                              ws_sub_in = WS_LF;
                           end
                        end
                        WS_LF: ws_sub_in = pop_item.is_cr ? WS_LFCR : WS_LINE;
                        default: begin
                           if (pop_item.is_lf) begin
                              ws_sub_in = WS_KEY;
                              phase_in  = PH_WS_OPEN;
                              event_in  = EV_WS_DONE;
                           end else begin
                              ws_sub_in = WS_LINE;
                           end
                        end
                     endcase
                  end
                  PH_CLOSE: begin
                     if (keep_conn_ff) begin
                        phase_in = PH_METHOD;
                     end else begin
                        event_in = EV_CLOSE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            MODE_TICK: begin
               if (phase_ff inside {[PH_METHOD:PH_INFLAG]}) begin
                  if (idle_ff != 16'hffff) begin
                     idle_in = idle_ff + 16'd1;
                  end
                  if (idle_ff > idle_limit_ff) begin
                     phase_in = PH_CLOSE;
                     event_in = EV_CLOSE;
                  end
               end
            end
            MODE_OPEN: begin
               phase_in  = PH_METHOD;
               count_in  = '0;
               prefix_in = 1'b1;
               ws_sub_in = WS_KEY;
               idle_in   = 16'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RESET;
         keep_conn_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IDLE_LIMIT: idle_limit_ff <= csr_write_data;
            CSR_KEEP_CONN:  keep_conn_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NONE;
         count_ff     <= '0;
         prefix_ff    <= 1'b1;
         ws_sub_ff    <= WS_KEY;
         idle_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         prefix_ff    <= prefix_in;
         ws_sub_ff    <= ws_sub_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         event_ff <= event_in;
         pbyte_ff <= pbyte_in;
         plen_ff  <= plen_in;
         ws_ff    <= ws_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= KEEP_MAX)
      else $error("kept path count beyond limit");
   a_ws_sub_phase: assert property (@(posedge clock) disable iff (reset)
      ws_sub_ff != WS_KEY |-> phase_ff == PH_WS)
      else $error("websocket scanner active outside websocket phase");
   a_ws_flag_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ws_ff |-> event_ff == EV_PATH_DONE)
      else $error("websocket flag on wrong event");
   a_ws_needs_prefix: assert property (@(posedge clock) disable iff (reset)
      take && phase_in == PH_WS && phase_ff == PH_PATH |-> prefix_ff)
      else $error("websocket phase entered without prefix match");
`endif

endmodule
